/* hdl/i2cmbs_pkg.sv */
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Shared word types, command codes, sequencer state and configuration types.
// ----------------------------------------------------------------------------
package i2cmbs_pkg;

	localparam int BITS_PER_BYTE = 8;

	typedef enum logic [2:0] {
		OP_IDLE  = 3'd0,
		OP_START = 3'd1,
		OP_STOP  = 3'd2,
		OP_SEND  = 3'd3,
		OP_WACK  = 3'd4,
		OP_READ  = 3'd5
	} op_t;

	typedef enum logic {
		CFG_TICKS_PER_US = 1'b0,
		CFG_ACK_TIMEOUT  = 1'b1
	} cfg_idx_t;

	localparam logic [7:0] TICKS_PER_US_RESET = 8'd1;
	localparam logic [7:0] ACK_TIMEOUT_RESET  = 8'd250;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} req_word_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_failed;
		logic       cmd_rejected;
	} rsp_word_t;

	typedef struct packed {
		logic [7:0] ticks_per_us;
		logic [7:0] ack_timeout;
	} cfg_t;

	typedef struct packed {
		op_t         op;
		logic [3:0]  phase;
		logic [3:0]  bit_index;
		logic [7:0]  shift;
		logic [10:0] delay;
		logic [7:0]  ack_wait;
		logic        scl;
		logic        sda;
		logic        ack_choice;
		logic        ack_fail;
		logic [7:0]  rx_hold;
	} seq_state_t;

	localparam seq_state_t SEQ_STATE_RESET = '{
		op:         OP_IDLE,
		phase:      4'd0,
		bit_index:  4'd0,
		shift:      8'd0,
		delay:      11'd0,
		ack_wait:   8'd0,
		scl:        1'b1,
		sda:        1'b1,
		ack_choice: 1'b0,
		ack_fail:   1'b0,
		rx_hold:    8'd0
	};

endpackage

/* hdl/i2cmbs_cfg.sv */
// ----------------------------------------------------------------------------
// I2C master bit sequencer configuration registers
// Decodes the write port and holds the tick scale and the ACK timeout.
// ----------------------------------------------------------------------------
module i2cmbs_cfg import i2cmbs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_us <= TICKS_PER_US_RESET;
			cfg_q.ack_timeout  <= ACK_TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_TICKS_PER_US: cfg_q.ticks_per_us <= cfg_data;
				CFG_ACK_TIMEOUT:  cfg_q.ack_timeout  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hdl/i2cmbs_core.sv */
// ----------------------------------------------------------------------------
// I2C master bit sequencer core
// Holds the sequencer state and advances it by one tick per input word.
// ----------------------------------------------------------------------------
module i2cmbs_core import i2cmbs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  req_word_t req,
	input  cfg_t      cfg,
	output rsp_word_t rsp
);

	seq_state_t st_q;
	seq_state_t st_d;
	logic       rej_c;
	logic       done_c;

	function automatic logic [10:0] hold_ticks(input logic [2:0] units, input logic [7:0] tpu);
		logic [10:0] t;
		t = {3'd0, tpu};
		case (units)
			3'd1:    hold_ticks = t;
			3'd2:    hold_ticks = t << 1;
			3'd4:    hold_ticks = t << 2;
			default: hold_ticks = 11'd0;
		endcase
	endfunction

	always_comb begin : next_state
		seq_state_t s;
		logic       run;
		logic       fin;
		logic [3:0] nb;
		s      = st_q;
		run    = 1'b0;
		fin    = 1'b0;
		rej_c  = 1'b0;
		done_c = 1'b0;
		nb     = st_q.bit_index + 4'd1;
		if (s.op == OP_IDLE) begin
			if (req.command >= OP_START && req.command <= OP_READ) begin
				s.op       = op_t'(req.command);
				s.phase    = 4'd0;
				s.bit_index = 4'd0;
				s.ack_wait = 8'd0;
				s.delay    = 11'd0;
				if (s.op == OP_SEND) begin
					s.shift = req.tx_byte;
				end
				if (s.op == OP_READ) begin
					s.shift      = 8'd0;
					s.ack_choice = req.send_ack;
				end
				run = 1'b1;
			end
		end else begin
			rej_c = (req.command != OP_IDLE);
			if (s.delay != 11'd0) begin
				s.delay = s.delay - 11'd1;
			end else begin
				run = 1'b1;
			end
		end
		nb = s.bit_index + 4'd1;
		if (run) begin
			unique case (s.op)
				OP_START: begin
					case (s.phase)
						4'd0: begin s.sda = 1'b1; s.delay = 11'd0; s.phase = 4'd1; end
						4'd1: begin
							s.scl = 1'b1; s.delay = hold_ticks(3'd4, cfg.ticks_per_us);
							s.phase = 4'd2;
						end
						4'd2: begin
							s.sda = 1'b0; s.delay = hold_ticks(3'd4, cfg.ticks_per_us);
							s.phase = 4'd3;
						end
						default: begin s.scl = 1'b0; fin = 1'b1; end
					endcase
				end
				OP_STOP: begin
					case (s.phase)
						4'd0: begin s.scl = 1'b0; s.delay = 11'd0; s.phase = 4'd1; end
						4'd1: begin
							s.sda = 1'b0; s.delay = hold_ticks(3'd4, cfg.ticks_per_us);
							s.phase = 4'd2;
						end
						4'd2: begin
							s.scl = 1'b1; s.delay = hold_ticks(3'd4, cfg.ticks_per_us);
							s.phase = 4'd3;
						end
						4'd3: begin
							s.sda = 1'b1; s.delay = hold_ticks(3'd4, cfg.ticks_per_us);
							s.phase = 4'd4;
						end
						default: fin = 1'b1;
					endcase
				end
				OP_SEND: begin
					case (s.phase)
						4'd0: begin s.scl = 1'b0; s.delay = 11'd0; s.phase = 4'd1; end
						4'd1: begin
							s.sda   = s.shift[7];
							s.shift = {s.shift[6:0], 1'b0};
							s.delay = hold_ticks(3'd2, cfg.ticks_per_us);
							s.phase = 4'd2;
						end
						4'd2: begin
							s.scl = 1'b1; s.delay = hold_ticks(3'd2, cfg.ticks_per_us);
							s.phase = 4'd3;
						end
						4'd3: begin
							s.scl       = 1'b0;
							s.delay     = hold_ticks(3'd2, cfg.ticks_per_us);
							s.bit_index = nb;
							s.phase     = (nb < 4'(BITS_PER_BYTE)) ? 4'd1 : 4'd4;
						end
						default: fin = 1'b1;
					endcase
				end
				OP_WACK: begin
					case (s.phase)
						4'd0: begin
							s.sda = 1'b1; s.delay = hold_ticks(3'd1, cfg.ticks_per_us);
							s.phase = 4'd1;
						end
						4'd1: begin
							s.scl = 1'b1; s.delay = hold_ticks(3'd1, cfg.ticks_per_us);
							s.phase = 4'd2;
						end
						default: begin
							if (!req.sda_in) begin
								s.scl      = 1'b0;
								s.ack_fail = 1'b0;
								fin        = 1'b1;
							end else if (s.ack_wait < cfg.ack_timeout) begin
								s.ack_wait = s.ack_wait + 8'd1;
								s.delay    = 11'd0;
							end else begin
								// Timeout: fall into the stop sequence on this tick.
								s.ack_fail = 1'b1;
								s.op       = OP_STOP;
								s.scl      = 1'b0;
								s.delay    = 11'd0;
								s.phase    = 4'd1;
							end
						end
					endcase
				end
				OP_READ: begin
					case (s.phase)
						4'd0: begin
							s.scl = 1'b0; s.sda = 1'b1;
							s.delay = hold_ticks(3'd2, cfg.ticks_per_us);
							s.phase = 4'd1;
						end
						4'd1: begin
							s.scl       = 1'b1;
							s.shift     = {s.shift[6:0], req.sda_in};
							s.delay     = hold_ticks(3'd1, cfg.ticks_per_us);
							s.bit_index = nb;
							s.phase     = (nb < 4'(BITS_PER_BYTE)) ? 4'd0 : 4'd2;
						end
						4'd2: begin s.scl = 1'b0; s.delay = 11'd0; s.phase = 4'd3; end
						4'd3: begin
							s.sda = !s.ack_choice;
							s.delay = hold_ticks(3'd2, cfg.ticks_per_us);
							s.phase = 4'd4;
						end
						4'd4: begin
							s.scl = 1'b1; s.delay = hold_ticks(3'd2, cfg.ticks_per_us);
							s.phase = 4'd5;
						end
						default: begin
							s.scl     = 1'b0;
							s.rx_hold = s.shift;
							fin       = 1'b1;
						end
					endcase
				end
				default: fin = 1'b1;
			endcase
		end
		if (fin) begin
			s.op    = OP_IDLE;
			s.phase = 4'd0;
			s.delay = 11'd0;
			done_c  = 1'b1;
		end
		st_d = s;
	end

	always_comb begin : outputs
		rsp.scl_level    = st_d.scl;
		rsp.sda_level    = st_d.sda;
		rsp.busy_res     = (st_d.op != OP_IDLE);
		rsp.done_res     = done_c;
		rsp.rx_byte      = st_d.rx_hold;
		rsp.ack_failed   = st_d.ack_fail;
		rsp.cmd_rejected = rej_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= SEQ_STATE_RESET;
		end else if (step) begin
			st_q <= st_d;
		end
	end

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.op == OP_IDLE |-> st_q.phase == 4'd0 && st_q.delay == 11'd0)
		else $error("Idle sequencer holds a stale phase or delay.");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase < 4'd6)
		else $error("Sequencer phase out of range.");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && done_c |=> st_q.op == OP_IDLE)
		else $error("Command finished but the sequencer did not return to idle.");

endmodule

/* hdl/i2c_master_bit_sequencer.sv */
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// A word waits in the input register; its result word is then registered onto rsp.
// One word per cycle unless stalled; the sequencer state advances one tick per word.
// The input register and the result register each hold one word. While a result
// word is stalled, the input side takes one more word and then stalls.
// Reset: arst_n clears both pipeline valids, idles the sequencer with both
// lines released, and loads ticks_per_us 1 and ack_timeout 250.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer import i2cmbs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  req_word_t  req,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output rsp_word_t  rsp,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	req_word_t req_s1;
	logic      valid_s1;
	rsp_word_t rsp_s2;
	logic      valid_s2;
	rsp_word_t rsp_c;
	cfg_t      cfg;
	logic      advance;

	assign advance   = valid_s1 && (!valid_s2 || !rsp_stall);
	assign req_stall = valid_s1 && !advance;

	i2cmbs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	i2cmbs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.req    (req_s1),
		.cfg    (cfg),
		.rsp    (rsp_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_valid && !req_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!rsp_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= rsp_c;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	a_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("Input word dropped while waiting on the result register.");

	a_s2_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rsp_stall && !advance |=> valid_s2 && $stable(rsp_s2))
		else $error("Stalled result word was lost or changed.");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rsp_s2.done_res |-> !rsp_s2.busy_res)
		else $error("Result word reports done while still busy.");

endmodule

/* verif/tb_i2c_master_bit_sequencer.sv */
// ----------------------------------------------------------------------------
// I2C master bit sequencer testbench
// Sends tick words that carry commands and sampled SDA levels into the
// sequencer. A local model of the pin sequencer predicts every result word,
// and each result is checked field by field. The input side idles and the output
// side stalls at random. Directed tests cover the reset settings, zero delays, zero
// ACK timeout, the slowest clock setting and rejected commands. Random bus
// transactions with noise and broken command sequences follow.
// ----------------------------------------------------------------------------
module tb_i2c_master_bit_sequencer;
	import i2cmbs_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_WORDS = 250;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	req_word_t  req = '0;
	logic       rsp_valid;
	logic       rsp_stall = 1'b0;
	rsp_word_t  rsp;
	logic       cfg_we = 1'b0;
	logic       cfg_index = 1'b0;
	logic [7:0] cfg_data = 8'd0;

	i2c_master_bit_sequencer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	logic [7:0]  cfg_ticks = TICKS_PER_US_RESET;
	logic [7:0]  cfg_ack_timeout = ACK_TIMEOUT_RESET;
	op_t         seq_op = OP_IDLE;
	logic [3:0]  seq_phase = 4'd0;
	logic [3:0]  seq_bit = 4'd0;
	logic [7:0]  seq_shift = 8'd0;
	logic [10:0] seq_delay = 11'd0;
	logic [7:0]  seq_ack_wait = 8'd0;
	logic        seq_scl = 1'b1;
	logic        seq_sda = 1'b1;
	logic        seq_ack_choice = 1'b0;
	logic        seq_ack_fail = 1'b0;
	logic [7:0]  seq_rx = 8'd0;

	rsp_word_t expected_bus_q[$];
	int        fails = 0;
	int        words_sent = 0;
	int        stall_left = 0;
	int        quiet_cycles = 0;
	bit        idle_on = 1'b1;

	function automatic void hold_units(int units);
		seq_delay = 11'(units * cfg_ticks);
	endfunction

	function automatic bit run_phase(logic sda);
		case (seq_op)
			OP_START: begin
				case (seq_phase)
					4'd0: begin seq_sda = 1'b1; hold_units(0); seq_phase = 4'd1; end
					4'd1: begin seq_scl = 1'b1; hold_units(4); seq_phase = 4'd2; end
					4'd2: begin seq_sda = 1'b0; hold_units(4); seq_phase = 4'd3; end
					default: begin seq_scl = 1'b0; return 1'b1; end
				endcase
				return 1'b0;
			end
			OP_STOP: begin
				case (seq_phase)
					4'd0: begin seq_scl = 1'b0; hold_units(0); seq_phase = 4'd1; end
					4'd1: begin seq_sda = 1'b0; hold_units(4); seq_phase = 4'd2; end
					4'd2: begin seq_scl = 1'b1; hold_units(4); seq_phase = 4'd3; end
					4'd3: begin seq_sda = 1'b1; hold_units(4); seq_phase = 4'd4; end
					default: return 1'b1;
				endcase
				return 1'b0;
			end
			OP_SEND: begin
				case (seq_phase)
					4'd0: begin seq_scl = 1'b0; hold_units(0); seq_phase = 4'd1; end
					4'd1: begin
						seq_sda = seq_shift[7];
						seq_shift = {seq_shift[6:0], 1'b0};
						hold_units(2);
						seq_phase = 4'd2;
					end
					4'd2: begin seq_scl = 1'b1; hold_units(2); seq_phase = 4'd3; end
					4'd3: begin
						seq_scl = 1'b0;
						hold_units(2);
						seq_bit = seq_bit + 4'd1;
						seq_phase = (seq_bit < BITS_PER_BYTE) ? 4'd1 : 4'd4;
					end
					default: return 1'b1;
				endcase
				return 1'b0;
			end
			OP_WACK: begin
				case (seq_phase)
					4'd0: begin seq_sda = 1'b1; hold_units(1); seq_phase = 4'd1; end
					4'd1: begin seq_scl = 1'b1; hold_units(1); seq_phase = 4'd2; end
					default: begin
						if (!sda) begin
							seq_scl = 1'b0;
							seq_ack_fail = 1'b0;
							return 1'b1;
						end
						if (seq_ack_wait < cfg_ack_timeout) begin
							seq_ack_wait = seq_ack_wait + 8'd1;
							hold_units(0);
						end else begin
							seq_ack_fail = 1'b1;
							seq_op = OP_STOP;
							seq_scl = 1'b0;
							hold_units(0);
							seq_phase = 4'd1;
						end
					end
				endcase
				return 1'b0;
			end
			OP_READ: begin
				case (seq_phase)
					4'd0: begin
						seq_scl = 1'b0;
						seq_sda = 1'b1;
						hold_units(2);
						seq_phase = 4'd1;
					end
					4'd1: begin
						seq_scl = 1'b1;
						seq_shift = {seq_shift[6:0], sda};
						hold_units(1);
						seq_bit = seq_bit + 4'd1;
						seq_phase = (seq_bit < BITS_PER_BYTE) ? 4'd0 : 4'd2;
					end
					4'd2: begin seq_scl = 1'b0; hold_units(0); seq_phase = 4'd3; end
					4'd3: begin
						seq_sda = seq_ack_choice ? 1'b0 : 1'b1;
						hold_units(2);
						seq_phase = 4'd4;
					end
					4'd4: begin seq_scl = 1'b1; hold_units(2); seq_phase = 4'd5; end
					default: begin
						seq_scl = 1'b0;
						seq_rx = seq_shift;
						return 1'b1;
					end
				endcase
				return 1'b0;
			end
			default: return 1'b1;
		endcase
	endfunction

	function automatic rsp_word_t advance_sequencer(req_word_t w);
		rsp_word_t r;
		bit        run;
		bit        done;
		bit        rejected;
		run = 1'b0;
		done = 1'b0;
		rejected = 1'b0;
		if (seq_op == OP_IDLE) begin
			if (w.command >= OP_START && w.command <= OP_READ) begin
				seq_op = op_t'(w.command);
				seq_phase = 4'd0;
				seq_bit = 4'd0;
				seq_ack_wait = 8'd0;
				seq_delay = 11'd0;
				if (w.command == OP_SEND)
					seq_shift = w.tx_byte;
				if (w.command == OP_READ) begin
					seq_shift = 8'd0;
					seq_ack_choice = w.send_ack;
				end
				run = 1'b1;
			end
		end else begin
			if (w.command != OP_IDLE)
				rejected = 1'b1;
			if (seq_delay != 11'd0)
				seq_delay = seq_delay - 11'd1;
			else
				run = 1'b1;
		end
		if (run) begin
			if (run_phase(w.sda_in)) begin
				seq_op = OP_IDLE;
				seq_phase = 4'd0;
				seq_delay = 11'd0;
				done = 1'b1;
			end
		end
		r.scl_level = seq_scl;
		r.sda_level = seq_sda;
		r.busy_res = (seq_op != OP_IDLE);
		r.done_res = done;
		r.rx_byte = seq_rx;
		r.ack_failed = seq_ack_fail;
		r.cmd_rejected = rejected;
		return r;
	endfunction

	task automatic send_word(input req_word_t w);
		int gap;
		gap = idle_on ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		words_sent++;
		expected_bus_q.push_back(advance_sequencer(w));
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (expected_bus_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic [7:0] ticks, input logic [7:0] timeout);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= CFG_TICKS_PER_US;
		cfg_data <= ticks;
		@(posedge clk);
		cfg_ticks = ticks;
		cfg_index <= CFG_ACK_TIMEOUT;
		cfg_data <= timeout;
		@(posedge clk);
		cfg_ack_timeout = timeout;
		cfg_we <= 1'b0;
	endtask

	// Issues one command and then ticks, with random noise commands, until the model sequencer is idle again.
	task automatic run_command(input logic [2:0] cmd, input logic [7:0] tx, input logic ack,
			input int sda_high_pct, input int noise_pct);
		req_word_t w;
		w.command = cmd;
		w.tx_byte = tx;
		w.send_ack = ack;
		w.sda_in = ($urandom_range(0, 99) < sda_high_pct);
		send_word(w);
		while (seq_op != OP_IDLE) begin
			w.command = ($urandom_range(0, 99) < noise_pct) ? 3'($urandom_range(1, 7)) : OP_IDLE;
			w.tx_byte = 8'($urandom);
			w.send_ack = 1'($urandom);
			w.sda_in = ($urandom_range(0, 99) < sda_high_pct);
			send_word(w);
		end
	endtask

	task automatic test_reset_state();
		run_command(OP_IDLE, 8'h00, 1'b0, 50, 0);
		run_command(OP_START, 8'h00, 1'b0, 50, 0);
		run_command(OP_SEND, 8'hA5, 1'b0, 50, 0);
		run_command(OP_WACK, 8'h00, 1'b0, 0, 0);
		run_command(OP_READ, 8'h00, 1'b1, 50, 0);
		run_command(OP_READ, 8'h00, 1'b0, 50, 0);
		run_command(OP_WACK, 8'h00, 1'b0, 100, 0);
		run_command(OP_STOP, 8'h00, 1'b0, 50, 0);
	endtask

	task automatic test_zero_settings();
		set_config(8'd0, 8'd0);
		run_command(OP_START, 8'h00, 1'b0, 50, 0);
		run_command(OP_SEND, 8'h00, 1'b0, 50, 0);
		run_command(OP_SEND, 8'hFF, 1'b1, 50, 0);
		run_command(OP_WACK, 8'h00, 1'b0, 100, 0);
		run_command(OP_READ, 8'h00, 1'b1, 100, 0);
		run_command(OP_READ, 8'h00, 1'b0, 0, 0);
		run_command(OP_WACK, 8'h00, 1'b0, 0, 0);
		run_command(OP_STOP, 8'h00, 1'b0, 50, 0);
	endtask

	task automatic test_rejected_commands();
		run_command(3'd6, 8'hFF, 1'b1, 50, 0);
		run_command(3'd7, 8'h00, 1'b0, 50, 0);
		run_command(OP_START, 8'h00, 1'b0, 50, 100);
		run_command(OP_SEND, 8'h3C, 1'b0, 50, 100);
		run_command(OP_READ, 8'h00, 1'b1, 50, 100);
		run_command(OP_STOP, 8'h00, 1'b0, 50, 100);
	endtask

	task automatic test_slow_settings();
		set_config(8'd255, 8'd255);
		run_command(OP_WACK, 8'h00, 1'b0, 0, 0);
	endtask

	task automatic test_random_traffic();
		int         base;
		logic [7:0] ticks;
		logic [7:0] timeout;
		int         noise;
		base = words_sent;
		while (words_sent - base < RANDOM_WORDS) begin
			case ($urandom_range(0, 9)) inside
				[0:3]: ticks = 8'd0;
				[4:7]: ticks = 8'd1;
				8: ticks = 8'd2;
				default: ticks = 8'($urandom_range(3, 6));
			endcase
			timeout = ($urandom_range(0, 9) == 0) ? 8'd250 : 8'($urandom_range(0, 12));
			set_config(ticks, timeout);
			idle_on = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(1, 3)) begin
				noise = ($urandom_range(0, 3) == 0) ? 10 : 0;
				if ($urandom_range(0, 4) == 0) begin
					repeat ($urandom_range(1, 4))
						run_command(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
							50, 20);
				end else begin
					run_command(OP_START, 8'($urandom), 1'($urandom), 50, noise);
					run_command(OP_SEND, 8'($urandom), 1'($urandom), 50, noise);
					run_command(OP_WACK, 8'($urandom), 1'($urandom),
						$urandom_range(0, 4) * 25, noise);
					repeat ($urandom_range(0, 3)) begin
						if ($urandom_range(0, 1) == 0) begin
							run_command(OP_SEND, 8'($urandom), 1'($urandom), 50, noise);
							run_command(OP_WACK, 8'($urandom), 1'($urandom),
								$urandom_range(0, 4) * 25, noise);
						end else begin
							run_command(OP_READ, 8'($urandom), 1'($urandom),
								$urandom_range(10, 90), noise);
						end
					end
					run_command(OP_STOP, 8'($urandom), 1'($urandom), 50, noise);
				end
			end
		end
		idle_on = 1'b1;
	endtask

	always @(posedge clk) begin : check_results
		rsp_word_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_bus_q.size() == 0) begin
					$error("result word arrived with nothing expected");
					fails++;
				end else begin
					want = expected_bus_q.pop_front();
					if (rsp.scl_level !== want.scl_level) begin
						$error("scl_level expected %0d got %0d", want.scl_level, rsp.scl_level);
						fails++;
					end
					if (rsp.sda_level !== want.sda_level) begin
						$error("sda_level expected %0d got %0d", want.sda_level, rsp.sda_level);
						fails++;
					end
					if (rsp.busy_res !== want.busy_res) begin
						$error("busy_res expected %0d got %0d", want.busy_res, rsp.busy_res);
						fails++;
					end
					if (rsp.done_res !== want.done_res) begin
						$error("done_res expected %0d got %0d", want.done_res, rsp.done_res);
						fails++;
					end
					if (rsp.rx_byte !== want.rx_byte) begin
						$error("rx_byte expected %0h got %0h", want.rx_byte, rsp.rx_byte);
						fails++;
					end
					if (rsp.ack_failed !== want.ack_failed) begin
						$error("ack_failed expected %0d got %0d", want.ack_failed, rsp.ack_failed);
						fails++;
					end
					if (rsp.cmd_rejected !== want.cmd_rejected) begin
						$error("cmd_rejected expected %0d got %0d", want.cmd_rejected,
							rsp.cmd_rejected);
						fails++;
					end
				end
				stall_left = idle_on ? $urandom_range(0, 7) : 0;
			end else if (rsp_stall) begin
				stall_left--;
			end
			rsp_stall <= (stall_left != 0);
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_zero_settings();
		test_rejected_commands();
		test_slow_settings();
		test_random_traffic();
		drain();
		if (fails == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* i2c_master_bit_sequencer.f */
hdl/i2cmbs_pkg.sv
hdl/i2cmbs_cfg.sv
hdl/i2cmbs_core.sv
hdl/i2c_master_bit_sequencer.sv
verif/tb_i2c_master_bit_sequencer.sv
